// ===== rtl/qce_pkg.sv =====
// ----------------------------------------------------------------------------
// qce_pkg
// Shared types and codes of the quadruple common-subexpression eliminator.
// ----------------------------------------------------------------------------
package qce_pkg;

  typedef struct packed {
    logic       block_start;
    logic [7:0] operator_code;
    logic [7:0] first_arg;
    logic [7:0] second_arg;
    logic [7:0] dest_name;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_operator;
    logic [7:0] out_first;
    logic [7:0] out_second;
    logic [7:0] out_dest;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUBST,
    ST_QUAD,
    ST_FINISH
  } eng_state_e;

endpackage

// ===== rtl/qce_if.sv =====
// ----------------------------------------------------------------------------
// qce_in_if / qce_out_if
// Valid/ready request channels carrying quadruples into and out of the block.
// ----------------------------------------------------------------------------
interface qce_in_if;
  logic               valid;
  logic               ready;
  qce_pkg::in_item_t  item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface qce_out_if;
  logic               valid;
  logic               ready;
  qce_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== rtl/qce_queue.sv =====
// ----------------------------------------------------------------------------
// qce_queue
// Two-entry request queue between the input port and the table engine.
// ----------------------------------------------------------------------------
module qce_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  qce_in_if.sink            in_i,
  output logic              pop_valid_o,
  output qce_pkg::in_item_t pop_item_o,
  input  logic              pop_i
);
  import qce_pkg::*;

  in_item_t    mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;

  assign in_i.ready  = (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop         = pop_i && pop_valid_o;
  assign pop_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_i.item;
    end
  end

endmodule

// ===== rtl/qce_engine.sv =====
// ----------------------------------------------------------------------------
// qce_engine
// Walks the substitution table, then the quadruple table, records the result
// and drives the registered output.
// ----------------------------------------------------------------------------
module qce_engine #(
  parameter int unsigned Depth = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  qce_pkg::in_item_t item_i,
  output logic              item_pop_o,
  qce_out_if.source         out_o
);
  import qce_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [CW-1:0] DepthCnt = CW'(Depth);

  logic [15:0] subst_mem [Depth];
  logic [31:0] quad_mem  [Depth];

  eng_state_e  state_q, state_d;
  logic [7:0]  op_q, a1_q, a2_q, dst_q;
  logic [CW-1:0] idx_q;
  logic [CW-1:0] sub_cnt_q, quad_cnt_q;
  logic        pend_q;
  logic [15:0] sub_rd_q;
  logic [31:0] quad_rd_q;
  logic        found_q;
  logic [7:0]  match_q;
  logic        out_vld_q;
  out_item_t   out_item_q;

  logic [CW-1:0] scan_cnt;
  logic        scan_done;
  logic        issue;
  logic        recorded;
  logic        out_free;
  logic        commit;
  logic        pop;
  logic        hit;

  assign scan_cnt  = (state_q == ST_SUBST) ? sub_cnt_q : quad_cnt_q;
  assign scan_done = (idx_q == scan_cnt);
  assign recorded  = found_q && (sub_cnt_q != DepthCnt);
  assign out_free  = !out_vld_q || out_o.ready;
  assign hit       = pend_q && !found_q && (quad_rd_q[31:8] == {op_q, a1_q, a2_q});

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (item_valid_i) state_d = ST_SUBST;
      ST_SUBST:  if (scan_done && !pend_q) state_d = ST_QUAD;
      ST_QUAD:   if (found_q || (scan_done && !pend_q)) state_d = ST_FINISH;
      ST_FINISH: if (recorded || out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop    = 1'b0;
    issue  = 1'b0;
    commit = 1'b0;
    unique case (state_q)
      ST_IDLE:   pop    = item_valid_i;
      ST_SUBST:  issue  = !scan_done;
      ST_QUAD:   issue  = !scan_done && !found_q;
      ST_FINISH: commit = recorded || out_free;
      default:   ;
    endcase
  end

  assign item_pop_o  = pop;
  assign out_o.valid = out_vld_q;
  assign out_o.item  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      pend_q     <= 1'b0;
      found_q    <= 1'b0;
      sub_cnt_q  <= '0;
      quad_cnt_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= issue;
      if (pop) begin
        idx_q   <= '0;
        found_q <= 1'b0;
        if (item_i.block_start) begin
          sub_cnt_q  <= '0;
          quad_cnt_q <= '0;
        end
      end else if (state_q == ST_SUBST && state_d == ST_QUAD) begin
        idx_q <= '0;
      end else if (issue) begin
        idx_q <= idx_q + 1'b1;
      end
      if (state_q == ST_QUAD && hit) begin
        found_q <= 1'b1;
      end
      if (commit) begin
        found_q <= 1'b0;
        if (recorded) begin
          sub_cnt_q <= sub_cnt_q + 1'b1;
        end
        if (quad_cnt_q != DepthCnt) begin
          quad_cnt_q <= quad_cnt_q + 1'b1;
        end
      end
      if (commit && !recorded) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload and table reads/writes
  always_ff @(posedge clk_i) begin
    if (pop) begin
      op_q  <= item_i.operator_code;
      a1_q  <= item_i.first_arg;
      a2_q  <= item_i.second_arg;
      dst_q <= item_i.dest_name;
    end else if (state_q == ST_SUBST && pend_q) begin
      // chained rewrite: each entry sees the value left by the older ones
      if (sub_rd_q[7:0] == a1_q) a1_q <= sub_rd_q[15:8];
      if (sub_rd_q[7:0] == a2_q) a2_q <= sub_rd_q[15:8];
    end
    if (state_q == ST_QUAD && hit) begin
      match_q <= quad_rd_q[7:0];
    end
    if (issue) begin
      sub_rd_q  <= subst_mem[idx_q[AW-1:0]];
      quad_rd_q <= quad_mem[idx_q[AW-1:0]];
    end
    if (commit && recorded) begin
      subst_mem[sub_cnt_q[AW-1:0]] <= {match_q, dst_q};
    end
    if (commit && (quad_cnt_q != DepthCnt)) begin
      quad_mem[quad_cnt_q[AW-1:0]] <= {op_q, a1_q, a2_q, dst_q};
    end
    if (commit && !recorded) begin
      out_item_q <= '{out_operator: op_q, out_first: a1_q,
                      out_second: a2_q, out_dest: dst_q};
    end
  end

`ifndef SYNTHESIS
  a_sub_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_cnt_q <= DepthCnt) else $error("substitution count overflow");

  a_quad_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    quad_cnt_q <= DepthCnt) else $error("quadruple count overflow");

  a_found_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (state_q == ST_QUAD || state_q == ST_FINISH))
    else $error("match flag outside table scan");

  a_no_emit_on_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && recorded && !out_vld_q) |=> !out_vld_q)
    else $error("recorded quadruple was emitted");
`endif

endmodule

// ===== rtl/quadruple_cse_eliminator_core.sv =====
// ----------------------------------------------------------------------------
// quadruple_cse_eliminator_core
// Local common-subexpression elimination over a stream of quadruples.
// ----------------------------------------------------------------------------
// order: an accepted item has its arguments rewritten through the substitution table,
//   then is matched against the quadruple table (a match stops the scan early), then
//   is committed; the engine takes no new item until it has finished the last one,
//   and the single read port of each table is walked one entry a cycle;
//   a kept quadruple also waits while the output register is still full
// reset: counts and control cleared asynchronously; tables need no clearing
module quadruple_cse_eliminator_core #(
  parameter int unsigned Depth = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qce_in_if.sink    in_i,
  qce_out_if.source out_o
);
  import qce_pkg::*;

  logic     q_valid;
  in_item_t q_item;
  logic     q_pop;

  qce_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .pop_valid_o (q_valid),
    .pop_item_o  (q_item),
    .pop_i       (q_pop)
  );

  qce_engine #(
    .Depth (Depth)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .out_o        (out_o)
  );

endmodule
